@@ rtl/pdc_pkg.sv @@
// ----------------------------------------------------------------------------
// PID drive controller package
// Register indexes, fixed field widths and constants of the PID controller.
// ----------------------------------------------------------------------------
package pdc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W     = 16;
  localparam int BAND_W     = 16;
  localparam int LIMIT_W    = 7;
  localparam int DRIVE_W    = 8;
  localparam int TIME_W     = 32;
  localparam int INTEG_W    = 48;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_BAND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_BAND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DRIVE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIVE  = 3'd6;

  // Milliseconds per second; the integral is kept in error-milliseconds.
  localparam logic [TIME_W-1:0] MS_PER_S = 32'd1000;

endpackage

@@ rtl/pdc_if.sv @@
// ----------------------------------------------------------------------------
// PID drive controller channels
// Valid/ready channels for step items and drive results.
// ----------------------------------------------------------------------------
interface pdc_step_if
  import pdc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic signed [SAMPLE_BITS-1:0] target;
  logic signed [SAMPLE_BITS-1:0] measured;
  logic [TIME_W-1:0]             now_ms;

  modport source (output valid, command, target, measured, now_ms, input ready);
  modport sink (input valid, command, target, measured, now_ms, output ready);
endinterface

interface pdc_drive_if
  import pdc_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;

  modport source (output valid, drive, input ready);
  modport sink (input valid, drive, output ready);
endinterface

@@ rtl/pid_drive_controller.sv @@
// ----------------------------------------------------------------------------
// PID drive controller
// Fixed-point PID with derivative on measurement, built around one bit-serial
// shift-add multiplier and one bit-serial restoring divider.
// ----------------------------------------------------------------------------
// A restart beat goes from acceptance straight to S_DONE; a compute beat runs
// through the serial divider (rate and integral/1000) and the multiplier passes.
// One step at a time; the next beat is taken once the last result
// sits in the output register. Reset is synchronous and restores register
// defaults and clears the integral, previous sample and previous time.
module pid_drive_controller
  import pdc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pdc_step_if.sink              step,
  pdc_drive_if.source           result
);

  localparam int EW   = SAMPLE_BITS + 1;
  localparam int RW   = SAMPLE_BITS + 11;
  localparam int DQ_W = 64;
  localparam int PW   = INTEG_W + 1;
  localparam int AW   = INTEG_W + 2;
  localparam int CMPW = 33;
  localparam int CNTW = 7;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RATE0 = 4'd1;
  localparam logic [3:0] S_RDIV  = 4'd2;
  localparam logic [3:0] S_BAND  = 4'd3;
  localparam logic [3:0] S_EMUL  = 4'd4;
  localparam logic [3:0] S_IACC  = 4'd5;
  localparam logic [3:0] S_IMUL0 = 4'd6;
  localparam logic [3:0] S_IMUL  = 4'd7;
  localparam logic [3:0] S_IDIV0 = 4'd8;
  localparam logic [3:0] S_IDIV  = 4'd9;
  localparam logic [3:0] S_PMUL0 = 4'd10;
  localparam logic [3:0] S_PMUL  = 4'd11;
  localparam logic [3:0] S_DMUL0 = 4'd12;
  localparam logic [3:0] S_DMUL  = 4'd13;
  localparam logic [3:0] S_CLAMP = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [GAIN_W-1:0]  prop_gain, integ_gain, deriv_gain;
  logic [BAND_W-1:0]  inner_band, outer_band;
  logic [LIMIT_W-1:0] min_drive, max_drive;

  logic [3:0]                    state;
  logic signed [INTEG_W-1:0]     integ;
  logic [SAMPLE_BITS-1:0]        prev_meas;
  logic [TIME_W-1:0]             prev_time;
  logic [TIME_W-1:0]             dt;
  logic                          err_neg, dm_neg, term_neg;
  logic [EW-1:0]                 emag, esh;
  logic [EW-1:0]                 dmag;
  logic [RW-1:0]                 rate_mag;
  logic [PW-1:0]                 pacc;
  logic [DQ_W-1:0]               mq, prod;
  logic [GAIN_W-1:0]             mg;
  logic [DQ_W-1:0]               dq;
  logic [TIME_W:0]               dr;
  logic [TIME_W-1:0]             dd;
  logic [CNTW-1:0]               cnt;
  logic signed [DQ_W-1:0]        sum;
  logic signed [DRIVE_W-1:0]     res;
  logic                          out_valid;
  logic signed [DRIVE_W-1:0]     out_drive;

  // Accept-time differences.
  logic signed [EW-1:0] err_w, dm_w;
  logic [EW-1:0]        emag_w, dmag_w;
  logic [RW-1:0]        dm1000;

  // Shared serial units.
  logic [DQ_W-1:0]   prod_next;
  logic [TIME_W:0]   rsh, dr_next;
  logic              ge;
  logic [DQ_W-1:0]   dq_next;
  logic [AW-1:0]     pdbl;
  logic [PW-1:0]     pacc_next;
  logic signed [AW-1:0] iacc;
  logic [INTEG_W-1:0]   imag;
  logic [DQ_W-1:0]      smag;
  logic [DQ_W-9:0]      dscaled;
  logic [LIMIT_W-1:0]   dlim;
  logic in_band, over_band;
  logic accept, out_free;

  assign accept   = step.valid && step.ready;
  assign out_free = !out_valid || result.ready;
  assign step.ready   = (state == S_IDLE);
  assign result.valid = out_valid;
  assign result.drive = out_drive;

  always_comb begin
    err_w  = $signed({step.target[SAMPLE_BITS-1], step.target})
           - $signed({step.measured[SAMPLE_BITS-1], step.measured});
    dm_w   = $signed({step.measured[SAMPLE_BITS-1], step.measured})
           - $signed({prev_meas[SAMPLE_BITS-1], prev_meas});
    emag_w = err_w[EW-1] ? EW'(-err_w) : EW'(err_w);
    dmag_w = dm_w[EW-1] ? EW'(-dm_w) : EW'(dm_w);
    // Times 1000 as 1024 - 16 - 8.
    dm1000 = {dmag, 10'b0} - RW'({dmag, 4'b0}) - RW'({dmag, 3'b0});
  end

  always_comb begin
    prod_next = prod + (mg[0] ? mq : '0);
    rsh       = {dr[TIME_W-1:0], dq[DQ_W-1]};
    ge        = rsh >= {1'b0, dd};
    dr_next   = ge ? rsh - {1'b0, dd} : rsh;
    dq_next   = {dq[DQ_W-2:0], ge};
    // Doubling the clamped partial product keeps min(true product, 2^48).
    pdbl      = {pacc, 1'b0} + AW'(esh[EW-1] ? dt : '0);
    pacc_next = (pdbl > (AW'(1) << INTEG_W)) ? (PW'(1) << INTEG_W) : pdbl[PW-1:0];
    iacc      = {{2{integ[INTEG_W-1]}}, integ}
              + (err_neg ? -$signed({1'b0, pacc}) : $signed({1'b0, pacc}));
    imag      = integ[INTEG_W-1] ? INTEG_W'(-integ) : INTEG_W'(integ);
    in_band   = (CMPW'(emag) > CMPW'(inner_band)) && (CMPW'(emag) < CMPW'(outer_band));
    over_band = CMPW'(emag) > CMPW'(outer_band);
    smag      = sum[DQ_W-1] ? DQ_W'(-sum) : DQ_W'(sum);
    dscaled   = smag[DQ_W-1:8];
    if (dscaled > (DQ_W-8)'(max_drive)) begin
      dlim = max_drive;
    end else if (dscaled != '0 && dscaled < (DQ_W-8)'(min_drive)) begin
      dlim = min_drive;
    end else begin
      dlim = dscaled[LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= GAIN_W'(256);
      integ_gain <= '0;
      deriv_gain <= '0;
      inner_band <= '0;
      outer_band <= '1;
      min_drive  <= '0;
      max_drive  <= '1;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_PROP_GAIN:  prop_gain  <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN: integ_gain <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN: deriv_gain <= cfg_data[GAIN_W-1:0];
        REG_INNER_BAND: inner_band <= cfg_data[BAND_W-1:0];
        REG_OUTER_BAND: outer_band <= cfg_data[BAND_W-1:0];
        REG_MIN_DRIVE:  min_drive  <= cfg_data[LIMIT_W-1:0];
        REG_MAX_DRIVE:  max_drive  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      integ     <= '0;
      prev_meas <= '0;
      prev_time <= '0;
      out_valid <= 1'b0;
    end else begin
      // In S_DONE the output register is refilled whenever it drains.
      if (out_valid && result.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            prev_time <= step.now_ms;
            if (step.command) begin
              integ     <= '0;
              prev_meas <= '0;
              res       <= '0;
              state     <= S_DONE;
            end else begin
              dt        <= step.now_ms - prev_time;
              err_neg   <= err_w[EW-1];
              emag      <= emag_w;
              dm_neg    <= dm_w[EW-1];
              dmag      <= dmag_w;
              prev_meas <= step.measured;
              state     <= S_RATE0;
            end
          end
        end
        S_RATE0: begin
          dr <= '0;
          dd <= dt;
          dq <= {dm1000, {(DQ_W-RW){1'b0}}};
          cnt <= CNTW'(RW);
          if (dt == '0) begin
            rate_mag <= '0;
            state    <= S_BAND;
          end else begin
            state <= S_RDIV;
          end
        end
        S_RDIV: begin
          dr  <= dr_next;
          dq  <= dq_next;
          cnt <= cnt - 1'b1;
          if (cnt == CNTW'(1)) begin
            rate_mag <= dq_next[RW-1:0];
            state    <= S_BAND;
          end
        end
        S_BAND: begin
          pacc <= '0;
          esh  <= emag;
          cnt  <= CNTW'(EW);
          if (in_band) begin
            state <= S_EMUL;
          end else begin
            if (over_band) begin
              integ <= '0;
            end
            state <= S_IMUL0;
          end
        end
        S_EMUL: begin
          pacc <= pacc_next;
          esh  <= {esh[EW-2:0], 1'b0};
          cnt  <= cnt - 1'b1;
          if (cnt == CNTW'(1)) begin
            state <= S_IACC;
          end
        end
        S_IACC: begin
          if (!iacc[AW-1] && iacc[AW-2:INTEG_W-1] != '0) begin
            integ <= {1'b0, {(INTEG_W-1){1'b1}}};
          end else if (iacc[AW-1] && iacc[AW-2:INTEG_W-1] != '1) begin
            integ <= {1'b1, {(INTEG_W-1){1'b0}}};
          end else begin
            integ <= iacc[INTEG_W-1:0];
          end
          state <= S_IMUL0;
        end
        S_IMUL0: begin
          mq       <= DQ_W'(imag);
          mg       <= integ_gain;
          prod     <= '0;
          term_neg <= integ[INTEG_W-1];
          cnt      <= CNTW'(GAIN_W);
          state    <= S_IMUL;
        end
        S_IMUL: begin
          prod <= prod_next;
          mq   <= {mq[DQ_W-2:0], 1'b0};
          mg   <= {1'b0, mg[GAIN_W-1:1]};
          cnt  <= cnt - 1'b1;
          if (cnt == CNTW'(1)) begin
            state <= S_IDIV0;
          end
        end
        S_IDIV0: begin
          dq    <= prod;
          dr    <= '0;
          dd    <= MS_PER_S;
          cnt   <= CNTW'(DQ_W);
          state <= S_IDIV;
        end
        S_IDIV: begin
          dr  <= dr_next;
          dq  <= dq_next;
          cnt <= cnt - 1'b1;
          if (cnt == CNTW'(1)) begin
            sum   <= term_neg ? -$signed(dq_next) : $signed(dq_next);
            state <= S_PMUL0;
          end
        end
        S_PMUL0: begin
          mq    <= DQ_W'(emag);
          mg    <= prop_gain;
          prod  <= '0;
          cnt   <= CNTW'(GAIN_W);
          state <= S_PMUL;
        end
        S_PMUL: begin
          prod <= prod_next;
          mq   <= {mq[DQ_W-2:0], 1'b0};
          mg   <= {1'b0, mg[GAIN_W-1:1]};
          cnt  <= cnt - 1'b1;
          if (cnt == CNTW'(1)) begin
            sum   <= err_neg ? sum - $signed(prod_next) : sum + $signed(prod_next);
            state <= S_DMUL0;
          end
        end
        S_DMUL0: begin
          mq    <= DQ_W'(rate_mag);
          mg    <= deriv_gain;
          prod  <= '0;
          cnt   <= CNTW'(GAIN_W);
          state <= S_DMUL;
        end
        S_DMUL: begin
          prod <= prod_next;
          mq   <= {mq[DQ_W-2:0], 1'b0};
          mg   <= {1'b0, mg[GAIN_W-1:1]};
          cnt  <= cnt - 1'b1;
          if (cnt == CNTW'(1)) begin
            // The rate carries the sign of the measurement change.
            sum   <= dm_neg ? sum + $signed(prod_next) : sum - $signed(prod_next);
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          res   <= sum[DQ_W-1] ? -$signed({1'b0, dlim}) : $signed({1'b0, dlim});
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_drive <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/sv/pid_drive_controller_tb.sv @@
// ----------------------------------------------------------------------------
// PID drive controller testbench
// Drives step beats with random gaps, predicts each drive value with an
// independent fixed-point PID model and checks every result beat in order.
// ----------------------------------------------------------------------------
module pid_drive_controller_tb;
  import pdc_pkg::*;

  localparam int SB = 16;
  localparam int LIMIT_CYCLES = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pdc_step_if #(.SAMPLE_BITS(SB)) step_ch ();
  pdc_drive_if result_ch ();

  pid_drive_controller #(.SAMPLE_BITS(SB)) uut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .step(step_ch.sink), .result(result_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state and register copies.
  logic [15:0] p_gain, i_gain, d_gain, band_in, band_out;
  logic [6:0] drv_min, drv_max;
  longint integ_acc;
  logic signed [15:0] last_meas;
  logic [31:0] last_ms;

  logic signed [7:0] drive_queue[$];
  int errors = 0;
  longint cycles = 0;
  int hold_max = 0;
  int beats_out = 0;
  int beats_seen = 0;
  int out_wait = 0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic logic signed [7:0] predict_drive(input logic cmd,
      input logic signed [15:0] tgt, input logic signed [15:0] meas,
      input logic [31:0] now);
    longint err, emag, rate, sum, drv, p, dmag;
    longint lim_max, lim_min;
    logic [31:0] dt;
    if (cmd) begin
      integ_acc = 0;
      last_meas = '0;
      last_ms = now;
      return 8'sd0;
    end
    dt = now - last_ms;
    rate = 0;
    if (dt != 0) rate = ((longint'(meas) - longint'(last_meas)) * 1000) / longint'(dt);
    err = longint'(tgt) - longint'(meas);
    emag = err < 0 ? -err : err;
    if (emag > band_in && emag < band_out) begin
      p = emag * longint'(dt);
      if (p > (64'sd1 <<< 48)) p = 64'sd1 <<< 48;
      integ_acc = integ_acc + (err < 0 ? -p : p);
      if (integ_acc > (64'sd1 <<< 47) - 1) integ_acc = (64'sd1 <<< 47) - 1;
      if (integ_acc < -(64'sd1 <<< 47)) integ_acc = -(64'sd1 <<< 47);
    end
    if (emag > band_out) integ_acc = 0;
    sum = longint'(p_gain) * err + (longint'(i_gain) * integ_acc) / 1000
        - longint'(d_gain) * rate;
    drv = sum / 256;
    dmag = drv < 0 ? -drv : drv;
    lim_max = drv_max;
    lim_min = drv_min;
    if (dmag > lim_max) dmag = lim_max;
    else if (dmag != 0 && dmag < lim_min) dmag = lim_min;
    drv = drv < 0 ? -dmag : dmag;
    last_meas = meas;
    last_ms = now;
    return drv[7:0];
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_PROP_GAIN:  p_gain = val;
      REG_INTEG_GAIN: i_gain = val;
      REG_DERIV_GAIN: d_gain = val;
      REG_INNER_BAND: band_in = val;
      REG_OUTER_BAND: band_out = val;
      REG_MIN_DRIVE:  drv_min = val[6:0];
      REG_MAX_DRIVE:  drv_max = val[6:0];
      default: ;
    endcase
  endtask

  task automatic send_step(input logic cmd, input logic signed [15:0] tgt,
      input logic signed [15:0] meas, input logic [31:0] now);
    int gap;
    gap = $urandom_range(0, 15);
    // With no gap, valid stays high and the next beat follows directly.
    if (gap != 0) begin
      step_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    step_ch.valid <= 1'b1;
    step_ch.command <= cmd;
    step_ch.target <= tgt;
    step_ch.measured <= meas;
    step_ch.now_ms <= now;
    do @(posedge clk); while (!step_ch.ready);
    drive_queue.push_back(predict_drive(cmd, tgt, meas, now));
    @(negedge clk);
  endtask

  // Waits for every expected beat plus the worst compute latency.
  task automatic drain();
    step_ch.valid <= 1'b0;
    while (drive_queue.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // Each result beat is followed by a freshly drawn number of idle cycles.
  always @(negedge clk) begin
    if (beats_out != beats_seen) begin
      beats_seen = beats_out;
      out_wait = $urandom_range(0, hold_max);
    end
    if (out_wait != 0) begin
      out_wait--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (!rst && result_ch.valid && result_ch.ready) begin
      beats_out++;
      if (drive_queue.size() == 0) begin
        report("unexpected drive beat", result_ch.drive, 0);
      end else begin
        if (result_ch.drive !== drive_queue[0])
          report("drive", result_ch.drive, drive_queue[0]);
        void'(drive_queue.pop_front());
      end
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    send_step(1'b1, 16'sd0, 16'sd0, 32'd100);
    send_step(1'b0, 16'sd32767, -16'sd32768, 32'd110);
    send_step(1'b0, -16'sd32768, 16'sd32767, 32'd110);
    send_step(1'b0, 16'sd5, 16'sd5, 32'hFFFF_FFFF);
    send_step(1'b0, 16'sd100, 16'sd0, 32'd3);
    send_step(1'b0, -16'sd1, 16'sd0, 32'd4);
    send_step(1'b1, 16'sd7, 16'sd9, 32'hFFFF_FFFF);
  endtask

  task automatic test_gains_and_bands();
    drain();
    write_reg(REG_INTEG_GAIN, 16'hFFFF);
    write_reg(REG_DERIV_GAIN, 16'h0100);
    write_reg(REG_INNER_BAND, 16'd10);
    write_reg(REG_OUTER_BAND, 16'd20000);
    write_reg(REG_MIN_DRIVE, 16'd20);
    write_reg(REG_MAX_DRIVE, 16'd90);
    send_step(1'b0, 16'sd1000, 16'sd0, 32'd1000);
    send_step(1'b0, 16'sd1000, 16'sd0, 32'hFFFF_0000);
    send_step(1'b0, 16'sd1000, 16'sd0, 32'h7FFF_0000);
    send_step(1'b0, 16'sd30000, -16'sd5000, 32'h7FFF_0001);
    send_step(1'b0, 16'sd2, 16'sd0, 32'h7FFF_0002);
    send_step(1'b0, 16'sd0, 16'sd0, 32'h7FFF_0002);
    drain();
    write_reg(REG_MIN_DRIVE, 16'hFFFF);
    write_reg(REG_MAX_DRIVE, 16'd0);
    write_reg(REG_PROP_GAIN, 16'd0);
    send_step(1'b0, 16'sd300, 16'sd0, 32'h7FFF_0010);
    drain();
    write_reg(REG_MAX_DRIVE, 16'd5);
    write_reg(REG_PROP_GAIN, 16'hFFFF);
    send_step(1'b0, 16'sd1, 16'sd0, 32'h7FFF_0011);
    drain();
  endtask

  task automatic test_random(input int count);
    logic [31:0] now;
    int r;
    now = $urandom;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 5) now = $urandom;
      else now = now + $urandom_range(0, r < 15 ? 0 : 50);
      if (r < 10)
        send_step(1'b1, 16'($urandom), 16'($urandom), now);
      else if (r < 70)
        send_step(1'b0, 16'($urandom_range(0, 2000) - 1000),
                  16'($urandom_range(0, 2000) - 1000), now);
      else
        send_step(1'b0, 16'($urandom), 16'($urandom), now);
    end
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 5; phase++) begin
      drain();
      hold_max = (phase % 2 == 0) ? 15 : 0;
      write_reg(REG_PROP_GAIN, 16'($urandom_range(0, 1024)));
      write_reg(REG_INTEG_GAIN, 16'($urandom));
      write_reg(REG_DERIV_GAIN, 16'($urandom_range(0, 64)));
      write_reg(REG_INNER_BAND, 16'($urandom_range(0, 50)));
      write_reg(REG_OUTER_BAND, phase == 4 ? 16'hFFFF : 16'($urandom_range(100, 3000)));
      write_reg(REG_MIN_DRIVE, 16'($urandom_range(0, 30)));
      write_reg(REG_MAX_DRIVE, phase == 3 ? 16'd127 : 16'($urandom_range(40, 127)));
      test_random(96);
    end
  endtask

  initial begin
    p_gain = 16'd256; i_gain = '0; d_gain = '0; band_in = '0; band_out = 16'hFFFF;
    drv_min = '0; drv_max = 7'd127;
    integ_acc = 0; last_meas = '0; last_ms = '0;
    step_ch.valid = 1'b0;
    step_ch.command = 1'b0;
    step_ch.target = '0;
    step_ch.measured = '0;
    step_ch.now_ms = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_gains_and_bands();
    test_random_settings();
    drain();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/pdc_pkg.sv
rtl/pdc_if.sv
rtl/pid_drive_controller.sv
tb/sv/pid_drive_controller_tb.sv
